[hdl/arc_pkg.sv]
`default_nettype none

package arc_pkg;

    localparam int IP_W     = 32;
    localparam int MAC_W    = 48;
    localparam int AGE_W    = 16;
    localparam int HANDLE_W = 8;
    localparam int CFG_W    = 48;

    typedef enum logic [1:0] {
        FUNC_RX    = 2'd0,
        FUNC_SEND  = 2'd1,
        FUNC_TICK  = 2'd2,
        FUNC_START = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ACT_NONE    = 2'd0,
        ACT_SEND    = 2'd1,
        ACT_REQUEST = 2'd2,
        ACT_REPLY   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        CFG_OWN_IP    = 2'd0,
        CFG_OWN_MAC   = 2'd1,
        CFG_ENTRY_LIFE = 2'd2,
        CFG_PEND_LIFE = 2'd3
    } t_cfg_index;

    localparam logic [10:0] MIN_PKT_LEN  = 11'd28;
    localparam logic [15:0] HW_TYPE_ETH  = 16'h0001;
    localparam logic [15:0] PROTO_IPV4   = 16'h0800;
    localparam logic [7:0]  HW_LEN_MAC   = 8'd6;
    localparam logic [7:0]  PROTO_LEN_IP = 8'd4;
    localparam logic [15:0] OP_REQUEST   = 16'd1;
    localparam logic [15:0] OP_REPLY     = 16'd2;

    localparam logic [AGE_W-1:0] ENTRY_LIFE_RST = 16'd60;
    localparam logic [AGE_W-1:0] PEND_LIFE_RST  = 16'd1;

    typedef struct packed {
        logic [1:0]          func;
        logic [10:0]         pkt_len;
        logic [15:0]         hw_type;
        logic [15:0]         proto_type;
        logic [7:0]          hw_addr_len;
        logic [7:0]          proto_addr_len;
        logic [15:0]         opcode;
        logic [IP_W-1:0]     src_ip;
        logic [MAC_W-1:0]    src_mac;
        logic [IP_W-1:0]     dst_ip;
        logic [HANDLE_W-1:0] packet_handle;
    } t_in_word;

    typedef struct packed {
        logic [1:0]          action;
        logic [MAC_W-1:0]    dest_mac;
        logic [IP_W-1:0]     arp_target_ip;
        logic [HANDLE_W-1:0] packet_handle_out;
    } t_out_word;

endpackage

`default_nettype wire

[hdl/arc_in_if.sv]
`default_nettype none

interface arc_in_if;
    logic              valid;
    logic              ready;
    arc_pkg::t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[hdl/arc_out_if.sv]
`default_nettype none

interface arc_out_if;
    logic               valid;
    logic               ready;
    arc_pkg::t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[hdl/arp_resolver_cache_core.sv]
// ARP resolver cache core.
// i_in carries one word per request: a parsed received ARP header, an
// outbound IP send, a one-second tick or a start command (func). o_out
// carries at most one action word per input word: forward an IP packet,
// broadcast an ARP request or send an ARP reply.
// Configuration (own IP/MAC, lifetimes) is written through the i_cfg_* port;
// the user must write it only while no words are in flight, which the block
// does not enforce. An accepted word passes through the input and output
// registers to o_out; one word per cycle is sustained while o_out does not
// stall. Both tables are register CAMs searched combinationally; a full
// address table evicts the entry with least remaining lifetime. Reset
// clears both tables, the staging registers and the lifetimes to their
// defaults; the block is ready in the first cycle after reset. When o_out
// stalls, the result holds, one more word is taken into the input register
// and i_in.ready then drops until the result is taken.
`default_nettype none

module arp_resolver_cache_core #(
    parameter int TABLE_ENTRIES   = 16,
    parameter int PENDING_ENTRIES = 4
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    arc_in_if.sink                         i_in,
    arc_out_if.source                      o_out,
    input  wire logic                      i_cfg_wr_en,
    input  wire logic [1:0]                i_cfg_index,
    input  wire logic [arc_pkg::CFG_W-1:0] i_cfg_wdata
);

    localparam int TIW = $clog2(TABLE_ENTRIES);
    localparam int TP  = 1 << TIW;
    localparam int KW  = arc_pkg::AGE_W + 1;

    // config
    logic [arc_pkg::IP_W-1:0]  r_own_ip;
    logic [arc_pkg::MAC_W-1:0] r_own_mac;
    logic [arc_pkg::AGE_W-1:0] r_entry_life;
    logic [arc_pkg::AGE_W-1:0] r_pend_life;

    // staging
    logic               r_in_valid;
    arc_pkg::t_in_word  r_in;
    logic               r_out_valid;
    arc_pkg::t_out_word r_out;
    logic               n_out_valid;
    arc_pkg::t_out_word n_out;

    // tables
    logic [TABLE_ENTRIES-1:0]    r_ent_valid;
    logic [arc_pkg::IP_W-1:0]    r_ent_ip   [TABLE_ENTRIES];
    logic [arc_pkg::MAC_W-1:0]   r_ent_mac  [TABLE_ENTRIES];
    logic [arc_pkg::AGE_W-1:0]   r_ent_age  [TABLE_ENTRIES];
    logic [PENDING_ENTRIES-1:0]  r_pend_valid;
    logic [arc_pkg::IP_W-1:0]    r_pend_ip     [PENDING_ENTRIES];
    logic [arc_pkg::HANDLE_W-1:0] r_pend_handle [PENDING_ENTRIES];
    logic [arc_pkg::AGE_W-1:0]   r_pend_age    [PENDING_ENTRIES];

    logic                         w_fire;
    logic                         w_hdr_ok;
    logic [arc_pkg::IP_W-1:0]     w_key;
    logic [TABLE_ENTRIES-1:0]     w_ent_hit;
    logic [TABLE_ENTRIES-1:0]     w_ent_free;
    logic [TABLE_ENTRIES-1:0]     w_ent_free_low;
    logic [TABLE_ENTRIES-1:0]     w_victim;
    logic [TABLE_ENTRIES-1:0]     w_learn_sel;
    logic [arc_pkg::MAC_W-1:0]    w_hit_mac;
    logic [PENDING_ENTRIES-1:0]   w_pend_hit;
    logic [PENDING_ENTRIES-1:0]   w_pend_free;
    logic [PENDING_ENTRIES-1:0]   w_pend_free_low;
    logic [arc_pkg::HANDLE_W-1:0] w_pend_handle;

    logic [KW-1:0]  w_node_key [2*TP-1];
    logic [TIW-1:0] w_node_idx [2*TP-1];

    assign w_fire      = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || w_fire;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    assign w_hdr_ok = (r_in.pkt_len >= arc_pkg::MIN_PKT_LEN)
                   && (r_in.hw_type == arc_pkg::HW_TYPE_ETH)
                   && (r_in.proto_type == arc_pkg::PROTO_IPV4)
                   && (r_in.hw_addr_len == arc_pkg::HW_LEN_MAC)
                   && (r_in.proto_addr_len == arc_pkg::PROTO_LEN_IP)
                   && ((r_in.opcode == arc_pkg::OP_REQUEST)
                       || (r_in.opcode == arc_pkg::OP_REPLY));

    assign w_key = (r_in.func == arc_pkg::FUNC_RX) ? r_in.src_ip : r_in.dst_ip;

    // CAM search, lowest free slot
    always_comb begin
        w_hit_mac     = '0;
        w_pend_handle = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            w_ent_hit[i] = r_ent_valid[i] && (r_ent_ip[i] == w_key);
            if (w_ent_hit[i]) begin
                w_hit_mac = w_hit_mac | r_ent_mac[i];
            end
        end
        for (int i = 0; i < PENDING_ENTRIES; i++) begin
            w_pend_hit[i] = r_pend_valid[i] && (r_pend_ip[i] == w_key);
            if (w_pend_hit[i]) begin
                w_pend_handle = w_pend_handle | r_pend_handle[i];
            end
        end
    end

    assign w_ent_free      = ~r_ent_valid;
    assign w_ent_free_low  = w_ent_free & (~w_ent_free + 1'b1);
    assign w_pend_free     = ~r_pend_valid;
    assign w_pend_free_low = w_pend_free & (~w_pend_free + 1'b1);

    // min-age tree for eviction; left wins ties (lowest index)
    for (genvar k = 0; k < TP; k++) begin : g_leaf
        if (k < TABLE_ENTRIES) begin : g_real
            assign w_node_key[TP-1+k] = {1'b0, r_ent_age[k]};
            assign w_node_idx[TP-1+k] = TIW'(k);
        end else begin : g_pad
            assign w_node_key[TP-1+k] = '1;
            assign w_node_idx[TP-1+k] = '0;
        end
    end
    for (genvar n = 0; n < TP - 1; n++) begin : g_node
        assign w_node_key[n] = (w_node_key[2*n+2] < w_node_key[2*n+1])
                               ? w_node_key[2*n+2] : w_node_key[2*n+1];
        assign w_node_idx[n] = (w_node_key[2*n+2] < w_node_key[2*n+1])
                               ? w_node_idx[2*n+2] : w_node_idx[2*n+1];
    end
    for (genvar v = 0; v < TABLE_ENTRIES; v++) begin : g_victim
        assign w_victim[v] = (w_node_idx[0] == TIW'(v));
    end

    assign w_learn_sel = (|w_ent_hit)  ? w_ent_hit :
                         (|w_ent_free) ? w_ent_free_low : w_victim;

    // result
    always_comb begin
        n_out_valid = r_out_valid && !o_out.ready;
        n_out       = r_out;
        if (w_fire) begin
            n_out_valid             = 1'b0;
            n_out.action            = arc_pkg::ACT_NONE;
            n_out.dest_mac          = '0;
            n_out.arp_target_ip     = '0;
            n_out.packet_handle_out = '0;
            unique case (arc_pkg::t_func'(r_in.func))
                arc_pkg::FUNC_RX: begin
                    if (w_hdr_ok && (|w_pend_hit)) begin
                        n_out_valid             = 1'b1;
                        n_out.action            = arc_pkg::ACT_SEND;
                        n_out.dest_mac          = r_in.src_mac;
                        n_out.packet_handle_out = w_pend_handle;
                    end else if (w_hdr_ok && (r_in.opcode == arc_pkg::OP_REQUEST)
                                 && (r_in.dst_ip == r_own_ip)) begin
                        n_out_valid         = 1'b1;
                        n_out.action        = arc_pkg::ACT_REPLY;
                        n_out.dest_mac      = r_in.src_mac;
                        n_out.arp_target_ip = r_in.src_ip;
                    end
                end
                arc_pkg::FUNC_SEND: begin
                    if (|w_ent_hit) begin
                        n_out_valid             = 1'b1;
                        n_out.action            = arc_pkg::ACT_SEND;
                        n_out.dest_mac          = w_hit_mac;
                        n_out.packet_handle_out = r_in.packet_handle;
                    end else if (!(|w_pend_hit) && (|w_pend_free)) begin
                        n_out_valid         = 1'b1;
                        n_out.action        = arc_pkg::ACT_REQUEST;
                        n_out.arp_target_ip = r_in.dst_ip;
                    end
                end
                arc_pkg::FUNC_TICK: begin
                    n_out_valid = 1'b0;
                end
                arc_pkg::FUNC_START: begin
                    n_out_valid         = 1'b1;
                    n_out.action        = arc_pkg::ACT_REQUEST;
                    n_out.arp_target_ip = r_own_ip;
                end
                default: begin
                    n_out_valid = 1'b0;
                end
            endcase
        end
    end

    // control and valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_ent_valid  <= '0;
            r_pend_valid <= '0;
            r_own_ip     <= '0;
            r_own_mac    <= '0;
            r_entry_life <= arc_pkg::ENTRY_LIFE_RST;
            r_pend_life  <= arc_pkg::PEND_LIFE_RST;
        end else begin
            r_out_valid <= n_out_valid;
            if (i_in.valid && i_in.ready) begin
                r_in_valid <= 1'b1;
            end else if (w_fire) begin
                r_in_valid <= 1'b0;
            end
            if (i_cfg_wr_en) begin
                unique case (arc_pkg::t_cfg_index'(i_cfg_index))
                    arc_pkg::CFG_OWN_IP:     r_own_ip     <= i_cfg_wdata[arc_pkg::IP_W-1:0];
                    arc_pkg::CFG_OWN_MAC:    r_own_mac    <= i_cfg_wdata;
                    arc_pkg::CFG_ENTRY_LIFE: r_entry_life <= i_cfg_wdata[arc_pkg::AGE_W-1:0];
                    arc_pkg::CFG_PEND_LIFE:  r_pend_life  <= i_cfg_wdata[arc_pkg::AGE_W-1:0];
                    default: r_own_ip <= r_own_ip;
                endcase
            end
            if (w_fire) begin
                unique case (arc_pkg::t_func'(r_in.func))
                    arc_pkg::FUNC_RX: begin
                        if (w_hdr_ok) begin
                            r_ent_valid  <= r_ent_valid | w_learn_sel;
                            r_pend_valid <= r_pend_valid & ~w_pend_hit;
                        end
                    end
                    arc_pkg::FUNC_SEND: begin
                        if (!(|w_ent_hit) && !(|w_pend_hit)) begin
                            r_pend_valid <= r_pend_valid | w_pend_free_low;
                        end
                    end
                    arc_pkg::FUNC_TICK: begin
                        for (int i = 0; i < TABLE_ENTRIES; i++) begin
                            if (r_ent_age[i] <= arc_pkg::AGE_W'(1)) begin
                                r_ent_valid[i] <= 1'b0;
                            end
                        end
                        for (int i = 0; i < PENDING_ENTRIES; i++) begin
                            if (r_pend_age[i] <= arc_pkg::AGE_W'(1)) begin
                                r_pend_valid[i] <= 1'b0;
                            end
                        end
                    end
                    arc_pkg::FUNC_START: begin
                        r_ent_valid <= r_ent_valid;
                    end
                    default: begin
                        r_ent_valid <= r_ent_valid;
                    end
                endcase
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (i_in.valid && i_in.ready) begin
            r_in <= i_in.data;
        end
        if (w_fire) begin
            unique case (arc_pkg::t_func'(r_in.func))
                arc_pkg::FUNC_RX: begin
                    if (w_hdr_ok) begin
                        for (int i = 0; i < TABLE_ENTRIES; i++) begin
                            if (w_learn_sel[i]) begin
                                r_ent_ip[i]  <= r_in.src_ip;
                                r_ent_mac[i] <= r_in.src_mac;
                                r_ent_age[i] <= r_entry_life;
                            end
                        end
                    end
                end
                arc_pkg::FUNC_SEND: begin
                    if (!(|w_ent_hit) && !(|w_pend_hit)) begin
                        for (int i = 0; i < PENDING_ENTRIES; i++) begin
                            if (w_pend_free_low[i]) begin
                                r_pend_ip[i]     <= r_in.dst_ip;
                                r_pend_handle[i] <= r_in.packet_handle;
                                r_pend_age[i]    <= r_pend_life;
                            end
                        end
                    end
                end
                arc_pkg::FUNC_TICK: begin
                    for (int i = 0; i < TABLE_ENTRIES; i++) begin
                        if (r_ent_valid[i] && (r_ent_age[i] > arc_pkg::AGE_W'(1))) begin
                            r_ent_age[i] <= r_ent_age[i] - 1'b1;
                        end
                    end
                    for (int i = 0; i < PENDING_ENTRIES; i++) begin
                        if (r_pend_valid[i] && (r_pend_age[i] > arc_pkg::AGE_W'(1))) begin
                            r_pend_age[i] <= r_pend_age[i] - 1'b1;
                        end
                    end
                end
                arc_pkg::FUNC_START: begin
                end
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

[hdl/arc_checker.sv]
`default_nettype none

module arc_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               i_in_ready,
    input wire logic               i_out_valid,
    input wire logic               i_out_ready,
    input wire arc_pkg::t_out_word i_out_word
);

    // stalled word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_word))
        else $error("stalled output word changed");

    // an empty output register never blocks the input
    a_in_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !i_out_valid |-> i_in_ready)
        else $error("input blocked with no pending result");

    a_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_word.action != arc_pkg::ACT_NONE)
        else $error("output word without action");

    a_request_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_word.action == arc_pkg::ACT_REQUEST)
        |-> (i_out_word.dest_mac == '0) && (i_out_word.packet_handle_out == '0))
        else $error("request carries mac or handle");

    a_reset_idle: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("output valid right after reset");

endmodule

bind arp_resolver_cache_core arc_checker u_arc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_word  (o_out.data)
);

`default_nettype wire

[verif/tb_arp_resolver_cache_core.sv]
`default_nettype none

module tb_arp_resolver_cache_core;
    import arc_pkg::*;

    localparam int ENTRIES     = 16;
    localparam int PARK_SLOTS  = 4;
    localparam int QUIET_LIMIT = 500;
    localparam int PHASE_WORDS = 275;

    class arp_checker;
        bit                  ent_vld    [ENTRIES];
        logic [IP_W-1:0]     ent_ip     [ENTRIES];
        logic [MAC_W-1:0]    ent_mac    [ENTRIES];
        logic [AGE_W-1:0]    ent_age    [ENTRIES];
        bit                  park_vld   [PARK_SLOTS];
        logic [IP_W-1:0]     park_ip    [PARK_SLOTS];
        logic [HANDLE_W-1:0] park_handle[PARK_SLOTS];
        logic [AGE_W-1:0]    park_age   [PARK_SLOTS];
        logic [IP_W-1:0]     own_ip;
        logic [MAC_W-1:0]    own_mac;
        logic [AGE_W-1:0]    ent_life;
        logic [AGE_W-1:0]    park_life;
        t_out_word           expected_actions[$];
        int unsigned         mismatches;
        int unsigned         act_count[4];
        int unsigned         func_count[4];
        int unsigned         ignored;

        function new();
            own_ip    = '0;
            own_mac   = '0;
            ent_life  = ENTRY_LIFE_RST;
            park_life = PEND_LIFE_RST;
            foreach (ent_vld[i]) begin
                ent_vld[i] = 1'b0;
                ent_ip[i]  = '0;
                ent_mac[i] = '0;
                ent_age[i] = '0;
            end
            foreach (park_vld[i]) begin
                park_vld[i]    = 1'b0;
                park_ip[i]     = '0;
                park_handle[i] = '0;
                park_age[i]    = '0;
            end
        endfunction

        function void set_reg(t_cfg_index idx, logic [CFG_W-1:0] v);
            case (idx)
                CFG_OWN_IP:     own_ip    = v[IP_W-1:0];
                CFG_OWN_MAC:    own_mac   = v[MAC_W-1:0];
                CFG_ENTRY_LIFE: ent_life  = v[AGE_W-1:0];
                CFG_PEND_LIFE:  park_life = v[AGE_W-1:0];
                default: ;
            endcase
        endfunction

        function int outstanding();
            return expected_actions.size();
        endfunction

        function void queue_action(t_action a, logic [MAC_W-1:0] mac, logic [IP_W-1:0] ip,
                                   logic [HANDLE_W-1:0] h);
            t_out_word r;
            r.action            = a;
            r.dest_mac          = mac;
            r.arp_target_ip     = ip;
            r.packet_handle_out = h;
            expected_actions.push_back(r);
            act_count[a]++;
        endfunction

        function int find_entry(logic [IP_W-1:0] ip);
            for (int i = 0; i < ENTRIES; i++)
                if (ent_vld[i] && ent_ip[i] == ip) return i;
            return -1;
        endfunction

        function int find_parked(logic [IP_W-1:0] ip);
            for (int i = 0; i < PARK_SLOTS; i++)
                if (park_vld[i] && park_ip[i] == ip) return i;
            return -1;
        endfunction

        // predicts the action (if any) caused by one accepted input word
        function void note_word(t_in_word w);
            int slot;
            int p;
            func_count[w.func]++;
            case (w.func)
                FUNC_RX: begin
                    if (w.pkt_len < MIN_PKT_LEN || w.hw_type != HW_TYPE_ETH ||
                        w.proto_type != PROTO_IPV4 || w.hw_addr_len != HW_LEN_MAC ||
                        w.proto_addr_len != PROTO_LEN_IP ||
                        (w.opcode != OP_REQUEST && w.opcode != OP_REPLY)) begin
                        ignored++;
                        return;
                    end
                    slot = find_entry(w.src_ip);
                    if (slot < 0) begin
                        for (int i = 0; i < ENTRIES; i++)
                            if (!ent_vld[i]) begin
                                slot = i;
                                break;
                            end
                    end
                    // full table: evict least remaining lifetime, lowest index wins
                    if (slot < 0) begin
                        slot = 0;
                        for (int i = 1; i < ENTRIES; i++)
                            if (ent_age[i] < ent_age[slot]) slot = i;
                    end
                    ent_vld[slot] = 1'b1;
                    ent_ip[slot]  = w.src_ip;
                    ent_mac[slot] = w.src_mac;
                    ent_age[slot] = ent_life;
                    p = find_parked(w.src_ip);
                    if (p >= 0) begin
                        park_vld[p] = 1'b0;
                        park_age[p] = '0;
                        queue_action(ACT_SEND, w.src_mac, '0, park_handle[p]);
                    end else if (w.opcode == OP_REQUEST && w.dst_ip == own_ip) begin
                        queue_action(ACT_REPLY, w.src_mac, w.src_ip, '0);
                    end
                end
                FUNC_SEND: begin
                    slot = find_entry(w.dst_ip);
                    if (slot >= 0) begin
                        queue_action(ACT_SEND, ent_mac[slot], '0, w.packet_handle);
                    end else if (find_parked(w.dst_ip) < 0) begin
                        for (int i = 0; i < PARK_SLOTS; i++)
                            if (!park_vld[i]) begin
                                park_vld[i]    = 1'b1;
                                park_ip[i]     = w.dst_ip;
                                park_handle[i] = w.packet_handle;
                                park_age[i]    = park_life;
                                queue_action(ACT_REQUEST, '0, w.dst_ip, '0);
                                break;
                            end
                    end
                end
                FUNC_TICK: begin
                    for (int i = 0; i < ENTRIES; i++)
                        if (ent_vld[i]) begin
                            if (ent_age[i] <= 1) begin
                                ent_vld[i] = 1'b0;
                                ent_age[i] = '0;
                            end else begin
                                ent_age[i] = ent_age[i] - 1'b1;
                            end
                        end
                    for (int i = 0; i < PARK_SLOTS; i++)
                        if (park_vld[i]) begin
                            if (park_age[i] <= 1) begin
                                park_vld[i] = 1'b0;
                                park_age[i] = '0;
                            end else begin
                                park_age[i] = park_age[i] - 1'b1;
                            end
                        end
                end
                default: begin
                    queue_action(ACT_REQUEST, '0, own_ip, '0);
                end
            endcase
        endfunction

        function string fmt(t_out_word a);
            return $sformatf("act %0d mac %012h ip %08h hdl %02h",
                             a.action, a.dest_mac, a.arp_target_ip, a.packet_handle_out);
        endfunction

        function void check_action(t_out_word got);
            t_out_word want;
            if (expected_actions.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: action word with none expected: %s", $time, fmt(got));
                return;
            end
            want = expected_actions.pop_front();
            if (got.action !== want.action || got.dest_mac !== want.dest_mac ||
                got.arp_target_ip !== want.arp_target_ip ||
                got.packet_handle_out !== want.packet_handle_out) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: mismatch\n  exp %s\n  got %s", $time, fmt(want), fmt(got));
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_wr_en;
    logic [1:0]           i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_wdata;
    bit                   steady;
    int                   quiet;
    logic [IP_W-1:0]      ip_pool[24];
    arp_checker           board;

    arc_in_if  in_if ();
    arc_out_if out_if ();

    arp_resolver_cache_core #(
        .TABLE_ENTRIES   (ENTRIES),
        .PENDING_ENTRIES (PARK_SLOTS)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_if),
        .o_out       (out_if),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (out_if.valid === 1'b1 && out_if.ready === 1'b1)
                board.check_action(out_if.data);
            if (in_if.valid === 1'b1 && in_if.ready === 1'b1)
                board.note_word(in_if.data);
            if ((out_if.valid === 1'b1 && out_if.ready === 1'b1) ||
                (in_if.valid === 1'b1 && in_if.ready === 1'b1))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT) begin
                $display("watchdog: no word moved for %0d cycles", QUIET_LIMIT);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // result sink with random stalls
    initial begin
        int gap;
        out_if.ready = 1'b0;
        forever begin
            gap = steady ? 0 : $urandom_range(0, 5);
            if (gap > 0) begin
                out_if.ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (out_if.valid !== 1'b1);
            @(negedge i_clk);
        end
    end

    // entered and left at a falling edge
    task automatic push_word(input t_in_word w);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= w;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [CFG_W-1:0] v);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= v;
        board.set_reg(idx, v);
        @(negedge i_clk);
    endtask

    task automatic apply_settings(input logic [IP_W-1:0] ip, input logic [MAC_W-1:0] mac,
                                  input logic [AGE_W-1:0] el, input logic [AGE_W-1:0] pl);
        in_if.valid <= 1'b0;
        while (board.outstanding() != 0) @(negedge i_clk);
        // a word with no result may still be in the pipe
        repeat (4) @(negedge i_clk);
        write_reg(CFG_OWN_IP, CFG_W'(ip));
        write_reg(CFG_OWN_MAC, mac);
        write_reg(CFG_ENTRY_LIFE, CFG_W'(el));
        write_reg(CFG_PEND_LIFE, CFG_W'(pl));
        i_cfg_wr_en <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic t_in_word noise_word();
        t_in_word w;
        w.func           = 2'($urandom);
        w.pkt_len        = 11'($urandom);
        w.hw_type        = 16'($urandom);
        w.proto_type     = 16'($urandom);
        w.hw_addr_len    = 8'($urandom);
        w.proto_addr_len = 8'($urandom);
        w.opcode         = 16'($urandom);
        w.src_ip         = $urandom;
        w.src_mac        = 48'({$urandom, $urandom});
        w.dst_ip         = $urandom;
        w.packet_handle  = 8'($urandom);
        return w;
    endfunction

    function automatic t_in_word good_rx(input logic [15:0] op, input logic [IP_W-1:0] sip,
                                         input logic [MAC_W-1:0] smac,
                                         input logic [IP_W-1:0] tip);
        t_in_word w;
        w                = noise_word();
        w.func           = FUNC_RX;
        w.pkt_len        = MIN_PKT_LEN;
        w.hw_type        = HW_TYPE_ETH;
        w.proto_type     = PROTO_IPV4;
        w.hw_addr_len    = HW_LEN_MAC;
        w.proto_addr_len = PROTO_LEN_IP;
        w.opcode         = op;
        w.src_ip         = sip;
        w.src_mac        = smac;
        w.dst_ip         = tip;
        return w;
    endfunction

    function automatic t_in_word send_to(input logic [IP_W-1:0] tip,
                                         input logic [HANDLE_W-1:0] h);
        t_in_word w;
        w               = noise_word();
        w.func          = FUNC_SEND;
        w.dst_ip        = tip;
        w.packet_handle = h;
        return w;
    endfunction

    function automatic t_in_word control(input t_func f);
        t_in_word w;
        w      = noise_word();
        w.func = f;
        return w;
    endfunction

    function automatic logic [IP_W-1:0] pick_ip();
        return ($urandom_range(0, 99) < 85) ? ip_pool[$urandom_range(0, 23)] : $urandom;
    endfunction

    task automatic directed_words();
        t_in_word w;
        push_word(control(FUNC_START));
        push_word(control(FUNC_TICK));
        w = good_rx(OP_REQUEST, 32'h0A00_0001, 48'h1111, board.own_ip);
        w.pkt_len = 11'd27;
        push_word(w);
        w.pkt_len = MIN_PKT_LEN;
        w.hw_type = 16'h0002;
        push_word(w);
        w.hw_type = HW_TYPE_ETH;
        w.proto_type = 16'h0806;
        push_word(w);
        w.proto_type = PROTO_IPV4;
        w.hw_addr_len = 8'd5;
        push_word(w);
        w.hw_addr_len = HW_LEN_MAC;
        w.proto_addr_len = 8'd3;
        push_word(w);
        w.proto_addr_len = PROTO_LEN_IP;
        w.opcode = 16'd0;
        push_word(w);
        w.opcode = 16'd3;
        push_word(w);
        // learn X, then forward to it
        push_word(good_rx(OP_REPLY, 32'h0A00_0001, 48'h0000_0000_0000, 32'h0A00_0099));
        push_word(send_to(32'h0A00_0001, 8'hFF));
        // request for our address from an all-ones MAC at maximum length
        w = good_rx(OP_REQUEST, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, board.own_ip);
        w.pkt_len = 11'h7FF;
        push_word(w);
        push_word(good_rx(OP_REQUEST, 32'h0000_0000, 48'h0000_0000_0003, 32'h0A00_0077));
        // miss parks, repeat miss drops, reply releases
        push_word(send_to(32'h0A00_0010, 8'hAA));
        push_word(send_to(32'h0A00_0010, 8'hBB));
        push_word(good_rx(OP_REPLY, 32'h0A00_0010, 48'hABCD_EF01_2345, 32'h0A00_0001));
        // fill the parking slots, then overflow
        for (int i = 0; i < PARK_SLOTS + 1; i++)
            push_word(send_to(32'h0B00_0000 + i, 8'(i)));
        push_word(control(FUNC_TICK));
        push_word(control(FUNC_TICK));
        push_word(send_to(32'h0A00_0001, 8'h00));
        push_word(control(FUNC_TICK));
        push_word(send_to(32'h0A00_0001, 8'h5A));
    endtask

    task automatic random_words(input int count);
        t_in_word w;
        int       done;
        int       pick;
        done = 0;
        while (done < count) begin
            if (done % 40 == 0) steady = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 36) begin
                w = good_rx($urandom_range(0, 1) ? OP_REQUEST : OP_REPLY, pick_ip(),
                            48'({$urandom, $urandom}),
                            $urandom_range(0, 1) ? board.own_ip : pick_ip());
                w.pkt_len = 11'($urandom_range(28, 2047));
                done++;
            end else if (pick < 66) begin
                w = send_to(pick_ip(), 8'($urandom));
                done++;
            end else if (pick < 78) begin
                w = control(FUNC_TICK);
                done++;
            end else if (pick < 83) begin
                w = control(FUNC_START);
                done++;
            end else begin
                // broken header
                w = good_rx($urandom_range(0, 1) ? OP_REQUEST : OP_REPLY, pick_ip(),
                            48'({$urandom, $urandom}), board.own_ip);
                case ($urandom_range(0, 6))
                    0: w.pkt_len = 11'($urandom_range(0, 27));
                    1: w.hw_type = HW_TYPE_ETH ^ 16'($urandom_range(1, 65535));
                    2: w.proto_type = PROTO_IPV4 ^ 16'($urandom_range(1, 65535));
                    3: w.hw_addr_len = HW_LEN_MAC ^ 8'($urandom_range(1, 255));
                    4: w.proto_addr_len = PROTO_LEN_IP ^ 8'($urandom_range(1, 255));
                    5: w.opcode = $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(3, 65535));
                    default: begin
                        w = noise_word();
                        w.func = FUNC_RX;
                    end
                endcase
                done++;
            end
            push_word(w);
        end
        steady = 1'b0;
    endtask

    initial begin
        quiet          = 0;
        steady         = 1'b0;
        i_rst_n        = 1'b0;
        i_cfg_wr_en    = 1'b0;
        i_cfg_index    = CFG_OWN_IP;
        i_cfg_wdata    = '0;
        in_if.valid    = 1'b0;
        in_if.data     = '0;
        board          = new();
        foreach (ip_pool[i]) ip_pool[i] = $urandom;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        apply_settings(32'hC0A8_0101, 48'h0200_0000_0001, 16'd3, 16'd2);
        directed_words();

        apply_settings(32'h0, 48'h0, 16'd60, 16'd1);
        random_words(PHASE_WORDS);
        apply_settings(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 16'hFFFF, 16'hFFFF);
        random_words(PHASE_WORDS);
        apply_settings(ip_pool[0], 48'({$urandom, $urandom}), 16'd1, 16'd1);
        random_words(PHASE_WORDS);
        apply_settings(ip_pool[1], 48'({$urandom, $urandom}), 16'd5, 16'hFFFF);
        random_words(PHASE_WORDS);
        apply_settings($urandom, 48'({$urandom, $urandom}), 16'hFFFF, 16'd3);
        random_words(PHASE_WORDS);
        apply_settings(ip_pool[2], 48'({$urandom, $urandom}), 16'($urandom_range(2, 20)),
                       16'($urandom_range(2, 10)));
        random_words(PHASE_WORDS);

        in_if.valid <= 1'b0;
        while (board.outstanding() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);

        $display("covered %0d headers (%0d rejected), %0d sends, %0d ticks, %0d starts, 7 settings",
                 board.func_count[FUNC_RX], board.ignored, board.func_count[FUNC_SEND],
                 board.func_count[FUNC_TICK], board.func_count[FUNC_START]);
        $display("actions: %0d forwards, %0d requests, %0d replies; %0d mismatches",
                 board.act_count[ACT_SEND], board.act_count[ACT_REQUEST],
                 board.act_count[ACT_REPLY], board.mismatches);
        if (board.mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
